>>> sv/brl_pkg.sv
`default_nettype none

package brl_pkg;

  // Field widths of the framebuffer interface.
  localparam int COORD_BITS    = 12;
  localparam int ERR_BITS      = COORD_BITS + 2;
  localparam int COLOR_BITS    = 32;
  localparam int ADDR_BITS     = 32;
  localparam int PITCH_BITS    = 16;
  localparam int PROD_BITS     = COORD_BITS + PITCH_BITS;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 1;

  // Reset values of the configuration registers.
  localparam logic [ADDR_BITS-1:0]  FRAME_BASE_RST = '0;
  localparam logic [PITCH_BITS-1:0] ROW_PITCH_RST  = 16'd16384;

  // Default queue depths.
  localparam int CMD_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_BASE = 1'b0,
    REG_ROW_PITCH  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_t;

  typedef struct packed {
    action_t                 action;
    logic [COORD_BITS-1:0]   x_start;
    logic [COORD_BITS-1:0]   y_start;
    logic [COORD_BITS-1:0]   x_end;
    logic [COORD_BITS-1:0]   y_end;
    logic [COLOR_BITS-1:0]   line_color;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]   pixel_x;
    logic [COORD_BITS-1:0]   pixel_y;
    logic [COLOR_BITS-1:0]   pixel_value;
    logic [ADDR_BITS-1:0]    byte_address;
    logic                    last_pixel;
  } out_item_t;

  // Classified command handed from the front end to the walker.
  typedef struct packed {
    logic                    load;
    logic                    steep;
    logic [COORD_BITS-1:0]   major_pos;
    logic [COORD_BITS-1:0]   major_stop;
    logic [COORD_BITS-1:0]   minor_pos;
    logic                    minor_down;
    logic [COORD_BITS-1:0]   major_delta;
    logic [COORD_BITS-1:0]   minor_delta;
    logic [COLOR_BITS-1:0]   color;
  } cmd_t;

endpackage

`default_nettype wire

>>> sv/brl_fifo.sv
`default_nettype none

module brl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             rd,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty,
  output logic                  full,
  output logic      [CNT_W-1:0] count
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign count = count_r;
  assign rdata = mem_r[rd_ptr_r];

  assign do_wr = wr & ~full;
  assign do_rd = rd & ~empty;

  // Pointer and occupancy update, with wrap at the last entry.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!do_wr && do_rd) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> sv/brl_front.sv
`default_nettype none

module brl_front
  import brl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire in_item_t in_item,
  output logic          full,
  input  wire logic     cmd_full,
  output logic          cmd_push,
  output cmd_t          cmd
);

  logic     hold_v_r, hold_v_nxt;
  in_item_t hold_r;
  logic     accept;

  logic [COORD_BITS-1:0] dx, dy;
  logic [COORD_BITS-1:0] a_maj, a_min, b_maj, b_min;
  logic [COORD_BITS-1:0] lo_maj, lo_min, hi_maj, hi_min;
  logic                  steep, swap;

  // The holding register takes a new transaction whenever it is empty or empties this cycle.
  assign full     = hold_v_r & cmd_full;
  assign accept   = push & ~full;
  assign cmd_push = hold_v_r & ~cmd_full;

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (accept) begin
      hold_v_nxt = 1'b1;
    end else if (cmd_push) begin
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= in_item;
    end
  end

  // Line setup: pick the major axis, then order the endpoints along it.
  always_comb begin
    dx = (hold_r.x_end > hold_r.x_start) ? hold_r.x_end - hold_r.x_start
                                         : hold_r.x_start - hold_r.x_end;
    dy = (hold_r.y_end > hold_r.y_start) ? hold_r.y_end - hold_r.y_start
                                         : hold_r.y_start - hold_r.y_end;
    steep = (dy > dx);
    a_maj = steep ? hold_r.y_start : hold_r.x_start;
    a_min = steep ? hold_r.x_start : hold_r.y_start;
    b_maj = steep ? hold_r.y_end   : hold_r.x_end;
    b_min = steep ? hold_r.x_end   : hold_r.y_end;
    swap   = (a_maj > b_maj);
    lo_maj = swap ? b_maj : a_maj;
    lo_min = swap ? b_min : a_min;
    hi_maj = swap ? a_maj : b_maj;
    hi_min = swap ? a_min : b_min;

    cmd.load        = (hold_r.action == ACT_LOAD);
    cmd.steep       = steep;
    cmd.major_pos   = lo_maj;
    cmd.major_stop  = hi_maj;
    cmd.minor_pos   = lo_min;
    cmd.minor_down  = !(lo_min < hi_min);
    cmd.major_delta = steep ? dy : dx;
    cmd.minor_delta = steep ? dx : dy;
    cmd.color       = hold_r.line_color;
  end

endmodule

`default_nettype wire

>>> sv/brl_back.sv
`default_nettype none

module brl_back
  import brl_pkg::*;
#(
  parameter int OUT_DEPTH = OUT_DEPTH_DEF,
  localparam int CNT_W = $clog2(OUT_DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cmd_t                  cmd,
  input  wire logic                  cmd_empty,
  output logic                       cmd_pop,
  input  wire logic [ADDR_BITS-1:0]  frame_base,
  input  wire logic [PITCH_BITS-1:0] row_pitch,
  input  wire logic [CNT_W-1:0]      out_count,
  output logic                       out_wr,
  output out_item_t                  out_item
);

  // Walker state.
  logic                         active_r, active_nxt;
  logic                         steep_r;
  logic [COORD_BITS-1:0]        maj_r, maj_nxt;
  logic [COORD_BITS-1:0]        stop_r;
  logic [COORD_BITS-1:0]        min_r, min_nxt;
  logic                         down_r;
  logic [COORD_BITS-1:0]        mdel_r;
  logic [COORD_BITS-1:0]        ndel_r;
  logic signed [ERR_BITS-1:0]   err_r, err_nxt, err_sub;
  logic [COLOR_BITS-1:0]        color_r;

  // Pixel stage between the walker and the output queue.
  logic                         s1_v_r;
  logic [COORD_BITS-1:0]        s1_px_r, s1_py_r;
  logic [COLOR_BITS-1:0]        s1_color_r;
  logic                         s1_last_r;
  logic [PROD_BITS-1:0]         s1_prod_r;

  logic                         credit_ok, emit, last;
  logic [COORD_BITS-1:0]        px, py;

  // A pixel is issued only if the output queue has room for it and for the one in flight.
  assign credit_ok = ({1'b0, out_count} + (CNT_W + 1)'(s1_v_r)) < (CNT_W + 1)'(OUT_DEPTH);
  assign cmd_pop   = ~cmd_empty & (cmd.load | ~active_r | credit_ok);
  assign emit      = cmd_pop & ~cmd.load & active_r;

  assign px   = steep_r ? min_r : maj_r;
  assign py   = steep_r ? maj_r : min_r;
  assign last = (maj_r == stop_r);

  // One Bresenham step: subtract the minor delta, and on a borrow move the minor axis.
  always_comb begin
    err_sub    = err_r - $signed({2'b00, ndel_r});
    err_nxt    = err_sub;
    min_nxt    = min_r;
    maj_nxt    = maj_r + COORD_BITS'(1);
    active_nxt = active_r & ~last;
    if (err_sub < 0) begin
      err_nxt = err_sub + $signed({2'b00, mdel_r});
      min_nxt = down_r ? min_r - COORD_BITS'(1) : min_r + COORD_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      s1_v_r   <= 1'b0;
    end else begin
      s1_v_r <= emit;
      if (cmd_pop && cmd.load) begin
        active_r <= 1'b1;
      end else if (emit) begin
        active_r <= active_nxt;
      end
    end
  end

  // Line state loads on a load command and advances on each emitted pixel.
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.load) begin
      steep_r <= cmd.steep;
      maj_r   <= cmd.major_pos;
      stop_r  <= cmd.major_stop;
      min_r   <= cmd.minor_pos;
      down_r  <= cmd.minor_down;
      mdel_r  <= cmd.major_delta;
      ndel_r  <= cmd.minor_delta;
      err_r   <= $signed({3'b000, cmd.major_delta[COORD_BITS-1:1]});
      color_r <= cmd.color;
    end else if (emit) begin
      maj_r <= maj_nxt;
      min_r <= min_nxt;
      err_r <= err_nxt;
    end
  end

  // Register the pixel with its row offset product.
  always_ff @(posedge clk) begin
    if (emit) begin
      s1_px_r    <= px;
      s1_py_r    <= py;
      s1_color_r <= color_r;
      s1_last_r  <= last;
      s1_prod_r  <= py * row_pitch;
    end
  end

  // Final address sum, written straight into the output queue.
  assign out_wr = s1_v_r;
  always_comb begin
    out_item.pixel_x      = s1_px_r;
    out_item.pixel_y      = s1_py_r;
    out_item.pixel_value  = s1_color_r;
    out_item.byte_address = frame_base + ADDR_BITS'(s1_prod_r)
                            + ADDR_BITS'({s1_px_r, 2'b00});
    out_item.last_pixel   = s1_last_r;
  end

endmodule

`default_nettype wire

>>> sv/bresenham_line_rasterizer.sv
// Throughput: one transaction per cycle while the output queue has room; each
// pixel is one error-term add and compare in the walker, with the row multiply
// registered beside it and the address add in the next stage.
// Reset (rst_n low, synchronous): both queues empty, no line active,
// frame base 0 and row pitch 16384.
`default_nettype none

module bresenham_line_rasterizer
  import brl_pkg::*;
#(
  parameter int CMD_DEPTH = CMD_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire in_item_t                 in_item,
  output logic                          full,
  output logic                          empty,
  input  wire logic                     pop,
  output out_item_t                     out_item,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  logic [ADDR_BITS-1:0]  frame_base_r;
  logic [PITCH_BITS-1:0] row_pitch_r;

  cmd_t                  front_cmd, back_cmd;
  logic                  cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic [CMD_CNT_W-1:0]  cmd_count;
  logic                  out_wr, out_full;
  logic [OUT_CNT_W-1:0]  out_count;
  out_item_t             out_wdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r <= FRAME_BASE_RST;
      row_pitch_r  <= ROW_PITCH_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_BASE: frame_base_r <= cfg_wdata;
        REG_ROW_PITCH:  row_pitch_r  <= cfg_wdata[PITCH_BITS-1:0];
        default: ;
      endcase
    end
  end

  brl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_item  (in_item),
    .full     (full),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd      (front_cmd)
  );

  brl_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (cmd_push),
    .wdata (front_cmd),
    .rd    (cmd_pop),
    .rdata (back_cmd),
    .empty (cmd_empty),
    .full  (cmd_full),
    .count (cmd_count)
  );

  brl_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (back_cmd),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .frame_base (frame_base_r),
    .row_pitch  (row_pitch_r),
    .out_count  (out_count),
    .out_wr     (out_wr),
    .out_item   (out_wdata)
  );

  brl_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (out_wr),
    .wdata (out_wdata),
    .rd    (pop),
    .rdata (out_item),
    .empty (empty),
    .full  (out_full),
    .count (out_count)
  );

  // The walker's credit check must keep the output queue from overflowing.
  a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_wr && out_full))
    else $error("pixel written into a full output queue");

  // The front end only pushes a command when the command queue has room.
  a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !cmd_full)
    else $error("command pushed into a full command queue");

  // Command queue occupancy stays within its depth.
  a_cmd_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_count <= CMD_CNT_W'(CMD_DEPTH))
    else $error("command queue count out of range");

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result pending after reset");

endmodule

`default_nettype wire
